// ----- design/qxm_pkg.sv -----
// Shared constants, types and register codes of the quad X mixer.
package qxm_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int SCALE_BITS    = 16;
  localparam int TT_W          = 25;
  localparam int TQ_W          = 24;
  localparam int GAIN_W        = 24;
  localparam int F_W           = 23;
  localparam int S_W           = 17;
  localparam int Q_W           = 18;
  localparam int RAW_W         = 51;
  localparam int DIV_STEPS     = 17;
  localparam int NUM_W         = F_W + 1 + SCALE_BITS;
  localparam int ADDR_W        = 4;
  localparam int DATA_W        = 32;
  localparam int IN_TDATA_W    = 104;
  localparam int OUT_TDATA_W   = 112;

  localparam logic [S_W-1:0] SCALE_ONE = S_W'(65536);
  localparam logic signed [Q_W-1:0] Q_SAT_HI = Q_W'(65537);
  localparam logic signed [Q_W-1:0] Q_SAT_LO = -Q_W'(1);

  localparam logic [GAIN_W-1:0] RP_RESET    = GAIN_W'(136296);
  localparam logic [GAIN_W-1:0] YG_RESET    = GAIN_W'(1638400);
  localparam logic [F_W-1:0]    FLOOR_RESET = F_W'(0);
  localparam logic [F_W-1:0]    CEIL_RESET  = F_W'(393216);

  typedef enum logic [1:0] {
    REG_RP_GAIN = 2'd0,
    REG_YAW_GAIN = 2'd1,
    REG_FLOOR = 2'd2,
    REG_CEILING = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [GAIN_W-1:0] rp;
    logic [GAIN_W-1:0] yg;
    logic [F_W-1:0]    fmin;
    logic [F_W-1:0]    fmax;
  } cfg_t;

endpackage

// ----- design/qxm_regs.sv -----
// Configuration register file with an APB-style access port.
module qxm_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [qxm_pkg::ADDR_W-1:0]   paddr,
  input  logic [qxm_pkg::DATA_W-1:0]   pwdata,
  output logic [qxm_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output qxm_pkg::cfg_t                cfg_o
);

  qxm_pkg::cfg_t     cfg_q;
  qxm_pkg::reg_idx_e idx;
  logic              wr;

  assign idx    = qxm_pkg::reg_idx_e'(paddr[qxm_pkg::ADDR_W-1:2]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rp   <= qxm_pkg::RP_RESET;
      cfg_q.yg   <= qxm_pkg::YG_RESET;
      cfg_q.fmin <= qxm_pkg::FLOOR_RESET;
      cfg_q.fmax <= qxm_pkg::CEIL_RESET;
    end else if (wr) begin
      unique case (idx)
        qxm_pkg::REG_RP_GAIN:  cfg_q.rp   <= pwdata[qxm_pkg::GAIN_W-1:0];
        qxm_pkg::REG_YAW_GAIN: cfg_q.yg   <= pwdata[qxm_pkg::GAIN_W-1:0];
        qxm_pkg::REG_FLOOR:    cfg_q.fmin <= pwdata[qxm_pkg::F_W-1:0];
        qxm_pkg::REG_CEILING:  cfg_q.fmax <= pwdata[qxm_pkg::F_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      qxm_pkg::REG_RP_GAIN:  prdata = qxm_pkg::DATA_W'(cfg_q.rp);
      qxm_pkg::REG_YAW_GAIN: prdata = qxm_pkg::DATA_W'(cfg_q.yg);
      qxm_pkg::REG_FLOOR:    prdata = qxm_pkg::DATA_W'(cfg_q.fmin);
      qxm_pkg::REG_CEILING:  prdata = qxm_pkg::DATA_W'(cfg_q.fmax);
      default:               prdata = '0;
    endcase
  end

endmodule

// ----- design/qxm_mix.sv -----
// Two-stage inverse mixing: gain products, then per-motor torque parts.
module qxm_mix #(
  parameter int FRAC_BITS = qxm_pkg::FRAC_BITS_DEF,
  parameter int A_W       = qxm_pkg::RAW_W - FRAC_BITS + 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic [qxm_pkg::TT_W-1:0]          total_thrust_i,
  input  logic signed [qxm_pkg::TQ_W-1:0]   torque_roll_i,
  input  logic signed [qxm_pkg::TQ_W-1:0]   torque_pitch_i,
  input  logic signed [qxm_pkg::TQ_W-1:0]   torque_yaw_i,
  input  qxm_pkg::cfg_t                     cfg_i,
  output logic                              valid_o,
  output logic signed [A_W-1:0]             a_o [4],
  output logic [qxm_pkg::F_W-1:0]           b_o
);

  localparam int RAW_W = qxm_pkg::RAW_W;
  localparam logic [RAW_W-1:0] HALF = RAW_W'(1) << (FRAC_BITS - 1);

  logic signed [qxm_pkg::TQ_W:0] dxy, sxy;
  logic signed [RAW_W-1:0]       p_q, q_q, y_q;
  logic [qxm_pkg::F_W-1:0]       b1_q, b2_q;
  logic                          v1_q, v2_q;
  logic signed [RAW_W-1:0]       raw [4];
  logic [RAW_W-1:0]              mag [4];
  logic [RAW_W-1:0]              rnd [4];
  logic signed [A_W-1:0]         a_d [4];
  logic signed [A_W-1:0]         a_q [4];

  assign dxy = (qxm_pkg::TQ_W+1)'(torque_pitch_i) - (qxm_pkg::TQ_W+1)'(torque_roll_i);
  assign sxy = (qxm_pkg::TQ_W+1)'(torque_pitch_i) + (qxm_pkg::TQ_W+1)'(torque_roll_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q  <= $signed({1'b0, cfg_i.rp}) * dxy;
      q_q  <= $signed({1'b0, cfg_i.rp}) * sxy;
      y_q  <= $signed({1'b0, cfg_i.yg}) * torque_yaw_i;
      b1_q <= total_thrust_i[qxm_pkg::TT_W-1:2];
      b2_q <= b1_q;
      a_q  <= a_d;
    end
  end

  always_comb begin
    raw[0] = y_q + p_q;
    raw[1] = y_q - p_q;
    raw[2] = q_q - y_q;
    raw[3] = -q_q - y_q;
    for (int i = 0; i < 4; i++) begin
      mag[i] = raw[i][RAW_W-1] ? RAW_W'(-raw[i]) : RAW_W'(raw[i]);
      rnd[i] = (mag[i] + HALF) >> FRAC_BITS;
      a_d[i] = raw[i][RAW_W-1] ? -A_W'(rnd[i]) : A_W'(rnd[i]);
    end
  end

  assign valid_o = v2_q;
  assign a_o     = a_q;
  assign b_o     = b2_q;

endmodule

// ----- design/qxm_sat_div.sv -----
// Pipelined restoring divider giving a floor quotient saturated to [-1, 65537].
module qxm_sat_div #(
  parameter int A_W = qxm_pkg::RAW_W - qxm_pkg::FRAC_BITS_DEF + 1
) (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [qxm_pkg::NUM_W-1:0]         num_i,
  input  logic [A_W-1:0]                    den_i,
  input  logic                              neg_i,
  output logic signed [qxm_pkg::Q_W-1:0]    q_o
);

  localparam int STEPS = qxm_pkg::DIV_STEPS;
  localparam int DW    = A_W + STEPS;
  localparam int S_W   = qxm_pkg::S_W;

  logic [DW-1:0]  r_q   [STEPS+1];
  logic [A_W-1:0] d_q   [STEPS+1];
  logic [S_W-1:0] quo_q [STEPS+1];
  logic           ovf_q [STEPS+1];
  logic           neg_q [STEPS+1];
  logic           zero_q[STEPS+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]    <= DW'(num_i);
      d_q[0]    <= den_i;
      quo_q[0]  <= '0;
      ovf_q[0]  <= DW'(num_i) >= (DW'(den_i) << STEPS);
      neg_q[0]  <= neg_i;
      zero_q[0] <= (num_i == '0);
    end
  end

  for (genvar j = 0; j < STEPS; j++) begin : g_step
    localparam int K = STEPS - 1 - j;
    logic [DW-1:0] sub;
    logic          fit;
    assign sub = DW'(d_q[j]) << K;
    assign fit = r_q[j] >= sub;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[j+1]    <= fit ? r_q[j] - sub : r_q[j];
        quo_q[j+1]  <= fit ? quo_q[j] | (S_W'(1) << K) : quo_q[j];
        d_q[j+1]    <= d_q[j];
        ovf_q[j+1]  <= ovf_q[j];
        neg_q[j+1]  <= neg_q[j];
        zero_q[j+1] <= zero_q[j];
      end
    end
  end

  always_comb begin
    if (neg_q[STEPS]) begin
      q_o = zero_q[STEPS] ? '0 : qxm_pkg::Q_SAT_LO;
    end else if (ovf_q[STEPS] || ($signed({1'b0, quo_q[STEPS]}) > qxm_pkg::Q_SAT_HI)) begin
      q_o = qxm_pkg::Q_SAT_HI;
    end else begin
      q_o = $signed({1'b0, quo_q[STEPS]});
    end
  end

endmodule

// ----- design/quad_x_mixer_torque_scaling.sv -----
// Top level of the quad X motor mixer with torque scaling.
// An accepted item passes the two mixing stages, the divider stages, then the scale, product and output registers.
// Throughput: one item per cycle; the whole pipeline advances when the output
// register is empty or its item is taken, so a stall holds every stage.
// The restoring dividers (an input register, then one quotient bit per stage) set the depth.
// Reset clears all valid bits and loads the register reset values.
module quad_x_mixer_torque_scaling #(
  parameter int FRAC_BITS = qxm_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // total_thrust[24:0], torque_roll[48:25], torque_pitch[72:49], torque_yaw[96:73]
  input  logic [qxm_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // thrust_front_right[22:0], thrust_back_left[45:23], thrust_front_left[68:46],
  // thrust_back_right[91:69], torque_scale[108:92]
  output logic [qxm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [qxm_pkg::ADDR_W-1:0]         paddr,
  input  logic [qxm_pkg::DATA_W-1:0]         pwdata,
  output logic [qxm_pkg::DATA_W-1:0]         prdata,
  output logic                               pready
);

  localparam int A_W     = qxm_pkg::RAW_W - FRAC_BITS + 1;
  localparam int F_W     = qxm_pkg::F_W;
  localparam int S_W     = qxm_pkg::S_W;
  localparam int Q_W     = qxm_pkg::Q_W;
  localparam int NUM_W   = qxm_pkg::NUM_W;
  localparam int DIV_LAT = qxm_pkg::DIV_STEPS + 1;
  localparam int PROD_W  = A_W + S_W + 1;
  localparam int SB      = qxm_pkg::SCALE_BITS;
  localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (SB - 1);

  qxm_pkg::cfg_t           cfg;
  logic                    en;
  logic                    v2;
  logic signed [A_W-1:0]   a2 [4];
  logic [F_W-1:0]          b2;

  logic signed [Q_W-1:0]   quo [4][2];
  logic                    v_dl_q [DIV_LAT];
  logic signed [A_W-1:0]   a_dl_q [DIV_LAT][4];
  logic [F_W-1:0]          b_dl_q [DIV_LAT];

  logic signed [Q_W-1:0]   s_low, s_high;
  logic [S_W-1:0]          s_d, s3_q, s4_q;
  logic signed [A_W-1:0]   a3_q [4];
  logic [F_W-1:0]          b3_q, b4_q;
  logic                    v3_q, v4_q;
  logic signed [PROD_W-1:0] prod4_q [4];
  logic [F_W-1:0]          thr [4];
  logic                    out_v_q;
  logic [qxm_pkg::OUT_TDATA_W-1:0] out_q;

  assign en              = !out_v_q || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_q;

  qxm_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o (cfg)
  );

  qxm_mix #(.FRAC_BITS(FRAC_BITS), .A_W(A_W)) u_mix (
    .clk_i, .rst_ni,
    .en_i           (en),
    .valid_i        (s_axis_tvalid_i),
    .total_thrust_i (s_axis_tdata_i[24:0]),
    .torque_roll_i  ($signed(s_axis_tdata_i[48:25])),
    .torque_pitch_i ($signed(s_axis_tdata_i[72:49])),
    .torque_yaw_i   ($signed(s_axis_tdata_i[96:73])),
    .cfg_i          (cfg),
    .valid_o        (v2),
    .a_o            (a2),
    .b_o            (b2)
  );

  for (genvar i = 0; i < 4; i++) begin : g_motor
    logic            a_neg;
    logic [A_W-1:0]  a_mag;
    assign a_neg = a2[i][A_W-1];
    assign a_mag = a_neg ? A_W'(-a2[i]) : A_W'(a2[i]);
    for (genvar k = 0; k < 2; k++) begin : g_lim
      logic [F_W-1:0]        lim;
      logic signed [F_W+1:0] diff;
      logic [F_W:0]          dmag;
      logic [NUM_W-1:0]      num;
      assign lim  = (k == 0) ? cfg.fmin : cfg.fmax;
      assign diff = $signed({2'b00, lim}) - $signed({2'b00, b2});
      assign dmag = diff[F_W+1] ? (F_W+1)'(-diff) : (F_W+1)'(diff);
      assign num  = {dmag, SB'(0)};
      qxm_sat_div #(.A_W(A_W)) u_div (
        .clk_i,
        .en_i  (en),
        .num_i (num),
        .den_i (a_mag),
        .neg_i (diff[F_W+1] ^ a_neg),
        .q_o   (quo[i][k])
      );
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < DIV_LAT; j++) v_dl_q[j] <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      v_dl_q[0] <= v2;
      for (int j = 1; j < DIV_LAT; j++) v_dl_q[j] <= v_dl_q[j-1];
      v3_q    <= v_dl_q[DIV_LAT-1];
      v4_q    <= v3_q;
      out_v_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_dl_q[0] <= a2;
      b_dl_q[0] <= b2;
      for (int j = 1; j < DIV_LAT; j++) begin
        a_dl_q[j] <= a_dl_q[j-1];
        b_dl_q[j] <= b_dl_q[j-1];
      end
      s3_q <= s_d;
      a3_q <= a_dl_q[DIV_LAT-1];
      b3_q <= b_dl_q[DIV_LAT-1];
      for (int i = 0; i < 4; i++) prod4_q[i] <= $signed({1'b0, s3_q}) * a3_q[i];
      b4_q  <= b3_q;
      s4_q  <= s3_q;
      out_q <= {3'b000, s4_q, thr[3], thr[2], thr[1], thr[0]};
    end
  end

  always_comb begin
    logic signed [Q_W-1:0] lo, hi;
    s_low  = '0;
    s_high = $signed({1'b0, qxm_pkg::SCALE_ONE});
    for (int i = 0; i < 4; i++) begin
      lo = (quo[i][0] < quo[i][1]) ? quo[i][0] : quo[i][1];
      hi = (quo[i][0] < quo[i][1]) ? quo[i][1] : quo[i][0];
      if (a_dl_q[DIV_LAT-1][i] != '0) begin
        if (lo > s_low)  s_low  = lo;
        if (hi < s_high) s_high = hi;
      end
    end
    s_d = (s_low <= s_high) ? S_W'(s_high) : '0;
  end

  always_comb begin
    logic [PROD_W-1:0]       pmag;
    logic [PROD_W-1:0]       prnd;
    logic signed [PROD_W:0]  f;
    for (int i = 0; i < 4; i++) begin
      pmag = prod4_q[i][PROD_W-1] ? PROD_W'(-prod4_q[i]) : PROD_W'(prod4_q[i]);
      prnd = (pmag + HALF) >> SB;
      f = prod4_q[i][PROD_W-1] ? $signed((PROD_W+1)'(b4_q)) - $signed((PROD_W+1)'(prnd))
                               : $signed((PROD_W+1)'(b4_q)) + $signed((PROD_W+1)'(prnd));
      if (f < $signed((PROD_W+1)'(cfg.fmin))) begin
        thr[i] = cfg.fmin;
      end else if (f > $signed((PROD_W+1)'(cfg.fmax))) begin
        thr[i] = cfg.fmax;
      end else begin
        thr[i] = F_W'(f);
      end
    end
  end

  a_scale_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[108:92] <= qxm_pkg::SCALE_ONE))
    else $error("torque scale above one");

  a_thrust_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (cfg.fmin <= cfg.fmax)) |->
      ((m_axis_tdata_o[22:0] >= cfg.fmin) && (m_axis_tdata_o[22:0] <= cfg.fmax)))
    else $error("thrust outside limits");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(v_dl_q[DIV_LAT-1]) && $stable(v3_q) && $stable(v4_q)))
    else $error("pipeline moved during stall");

endmodule
